// ===== src/mlp_pkg.sv =====
// ============================================================================
// mlp_pkg
// Shared constants, types and the sigmoid table generator for the 9-4-1
// perceptron.
// ============================================================================
package mlp_pkg;

    localparam int DATA_WIDTH          = 16;
    localparam int FRAC_BITS           = DATA_WIDTH - 4;
    localparam int N_INPUTS            = 9;
    localparam int N_HIDDEN            = 4;
    localparam int SIGMOID_ENTRIES_DEF = 256;
    localparam int PROB_WIDTH          = 16;
    localparam int SLOT_W              = 6;

    localparam int N_PARAMS   = N_INPUTS * N_HIDDEN + 2 * N_HIDDEN + 1;
    localparam int BIAS1_BASE = N_INPUTS * N_HIDDEN;
    localparam int W2_BASE    = BIAS1_BASE + N_HIDDEN;
    localparam int BIAS2_SLOT = W2_BASE + N_HIDDEN;

    localparam int PROD_W    = 2 * DATA_WIDTH;
    localparam int ACC_W     = PROD_W + 4;
    localparam int RND_W     = ACC_W - FRAC_BITS;
    localparam int LANE_W    = $clog2(N_HIDDEN);
    localparam int IN_IDX_W  = $clog2(N_INPUTS);

    localparam longint unsigned Q30_ONE = 64'd1 << 30;

    typedef enum logic [1:0] {
        K_WEIGHT     = 2'd0,
        K_BIAS       = 2'd1,
        K_OUT_WEIGHT = 2'd2,
        K_OUT_BIAS   = 2'd3
    } t_slot_kind;

    typedef struct packed {
        logic                         en;
        t_slot_kind                   kind;
        logic [LANE_W-1:0]            lane;
        logic [IN_IDX_W-1:0]          idx;
        logic signed [DATA_WIDTH-1:0] value;
    } t_load;

    typedef struct packed {
        logic                start;
        logic                mac;
        logic                act;
        logic                mul;
        logic [IN_IDX_W-1:0] cnt;
    } t_lane_ctl;

    typedef struct packed {
        logic sum;
        logic rnd;
        logic lut;
    } t_merge_ctl;

    // Entry k: round(65535 / (1 + exp(-centre))), Q30 exponential, elaboration only.
    function automatic logic [PROB_WIDTH-1:0] sigmoid_entry(input int unsigned k,
                                                            input int unsigned Entries);
        longint unsigned Pos;
        longint unsigned Neg;
        longint unsigned Num;
        longint unsigned Den;
        longint unsigned y;
        longint unsigned term;
        longint unsigned e;
        longint unsigned D;
        longint unsigned v;
        longint          sum;
        int unsigned     Step;
        int unsigned     Sq;
        Pos  = 64'(16 * k + 8);
        Neg  = 64'(8 * Entries);
        Num  = (Pos >= Neg) ? (Pos - Neg) : (Neg - Pos);
        Den  = 64'(Entries) * 64'd16;
        y    = (Num << 30) / Den;
        term = Q30_ONE;
        sum  = longint'(Q30_ONE);
        for (Step = 1; Step <= 24; Step++) begin
            term = ((term * y) >> 30) / 64'(Step);
            if (Step[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        e = (sum < 0) ? 64'd0 : longint'(sum);
        for (Sq = 0; Sq < 4; Sq++) begin
            e = (e * e) >> 30;
        end
        D = Q30_ONE + e;
        if (Pos >= Neg)
            v = (64'd65535 * Q30_ONE + D / 2) / D;
        else
            v = (64'd65535 * e + D / 2) / D;
        if (v > 64'd65535)
            v = 64'd65535;
        return v[PROB_WIDTH-1:0];
    endfunction

endpackage

// ===== src/mlp_in_if.sv =====
// ============================================================================
// mlp_in_if
// Input channel: load or infer request with valid/ready handshake.
// ============================================================================
interface mlp_in_if;
    import mlp_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [SLOT_W-1:0]            param_index;
    logic signed [DATA_WIDTH-1:0] param_value;
    logic signed [DATA_WIDTH-1:0] feature_0;
    logic signed [DATA_WIDTH-1:0] feature_1;
    logic signed [DATA_WIDTH-1:0] feature_2;
    logic signed [DATA_WIDTH-1:0] feature_3;
    logic signed [DATA_WIDTH-1:0] feature_4;
    logic signed [DATA_WIDTH-1:0] feature_5;
    logic signed [DATA_WIDTH-1:0] feature_6;
    logic signed [DATA_WIDTH-1:0] feature_7;
    logic signed [DATA_WIDTH-1:0] feature_8;

    modport source (
        output valid, action, param_index, param_value,
        output feature_0, feature_1, feature_2, feature_3, feature_4,
        output feature_5, feature_6, feature_7, feature_8,
        input  ready
    );

    modport sink (
        input  valid, action, param_index, param_value,
        input  feature_0, feature_1, feature_2, feature_3, feature_4,
        input  feature_5, feature_6, feature_7, feature_8,
        output ready
    );
endinterface

// ===== src/mlp_out_if.sv =====
// ============================================================================
// mlp_out_if
// Output channel: probability and saturation flag with valid/ready handshake.
// ============================================================================
interface mlp_out_if;
    import mlp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PROB_WIDTH-1:0] probability;
    logic                  saturated;

    modport source (output valid, probability, saturated, input ready);
    modport sink   (input valid, probability, saturated, output ready);
endinterface

// ===== src/mlp_lane.sv =====
// ============================================================================
// mlp_lane
// One hidden unit: weight store, serial MAC over the features, ReLU with
// saturation, and the product with its output-layer weight.
// ============================================================================
module mlp_lane #(
    parameter int LANE_ID = 0
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  mlp_pkg::t_load                               i_load,
    input  mlp_pkg::t_lane_ctl                           i_ctl,
    input  logic signed [mlp_pkg::DATA_WIDTH-1:0]        i_feat,
    output logic signed [mlp_pkg::PROD_W-1:0]            o_prod,
    output logic                                         o_sat
);
    import mlp_pkg::*;

    logic signed [DATA_WIDTH-1:0] r_w [N_INPUTS];
    logic signed [DATA_WIDTH-1:0] r_b1;
    logic signed [DATA_WIDTH-1:0] r_w2;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [DATA_WIDTH-1:0] r_hidden;
    logic signed [PROD_W-1:0]     r_prod;
    logic                         r_sat;

    logic                         w_mine;
    logic signed [PROD_W-1:0]     w_mac;
    logic [ACC_W-1:0]             w_rnd;
    logic [RND_W-1:0]             w_s;
    logic                         w_neg;
    logic                         w_over;
    logic signed [DATA_WIDTH-1:0] n_hidden;

    assign w_mine = i_load.en && (i_load.lane == LANE_W'(LANE_ID));
    assign w_mac  = i_feat * r_w[i_ctl.cnt];

    assign w_rnd  = r_acc + ACC_W'(1 << (FRAC_BITS - 1));
    assign w_s    = w_rnd[ACC_W-1:FRAC_BITS];
    assign w_neg  = w_s[RND_W-1];
    assign w_over = !w_neg && (|w_s[RND_W-2:DATA_WIDTH-1]);

    always_comb begin
        if (w_neg)
            n_hidden = '0;
        else if (w_over)
            n_hidden = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        else
            n_hidden = w_s[DATA_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_INPUTS; i++) begin
                r_w[i] <= '0;
            end
            r_b1  <= '0;
            r_w2  <= '0;
            r_sat <= 1'b0;
        end else begin
            if (w_mine) begin
                case (i_load.kind)
                    K_WEIGHT:     r_w[i_load.idx] <= i_load.value;
                    K_BIAS:       r_b1 <= i_load.value;
                    K_OUT_WEIGHT: r_w2 <= i_load.value;
                    default: ;
                endcase
            end
            if (i_ctl.act) begin
                r_sat <= w_over;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_acc <= {{(ACC_W-DATA_WIDTH-FRAC_BITS){r_b1[DATA_WIDTH-1]}}, r_b1,
                      {FRAC_BITS{1'b0}}};
        end else if (i_ctl.mac) begin
            r_acc <= r_acc + {{(ACC_W-PROD_W){w_mac[PROD_W-1]}}, w_mac};
        end
        if (i_ctl.act) begin
            r_hidden <= n_hidden;
        end
        if (i_ctl.mul) begin
            r_prod <= r_hidden * r_w2;
        end
    end

    assign o_prod = r_prod;
    assign o_sat  = r_sat;
endmodule

// ===== src/mlp_merge.sv =====
// ============================================================================
// mlp_merge
// Output neuron: sums the lane products with the output bias, rounds and
// clamps to Q4.12, and looks up the sigmoid table.
// ============================================================================
module mlp_merge #(
    parameter int SIGMOID_ENTRIES = mlp_pkg::SIGMOID_ENTRIES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mlp_pkg::t_load                        i_load,
    input  mlp_pkg::t_merge_ctl                   i_ctl,
    input  logic signed [mlp_pkg::PROD_W-1:0]     i_prod [mlp_pkg::N_HIDDEN],
    input  logic [mlp_pkg::N_HIDDEN-1:0]          i_hsat,
    output logic [mlp_pkg::PROB_WIDTH-1:0]        o_probability,
    output logic                                  o_saturated
);
    import mlp_pkg::*;

    localparam int TBL_W = $clog2(SIGMOID_ENTRIES);
    localparam int N_W   = $clog2(SIGMOID_ENTRIES + 1);
    localparam int OFS_W = DATA_WIDTH + N_W;

    logic [PROB_WIDTH-1:0]        w_rom [SIGMOID_ENTRIES];

    logic signed [DATA_WIDTH-1:0] r_b2;
    logic signed [ACC_W-1:0]      r_sum;
    logic                         r_hsat;
    logic [TBL_W-1:0]             r_idx;
    logic                         r_sat;
    logic [PROB_WIDTH-1:0]        r_prob;
    logic                         r_sat_out;

    logic signed [ACC_W-1:0]      w_sum;
    logic [ACC_W-1:0]             w_rnd;
    logic [RND_W-1:0]             w_s;
    logic                         w_hi;
    logic                         w_lo;
    logic [DATA_WIDTH-1:0]        w_clamp;
    logic [OFS_W-1:0]             w_ofs;

    for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_rom
        assign w_rom[k] = sigmoid_entry(k, SIGMOID_ENTRIES);
    end

    always_comb begin
        w_sum = {{(ACC_W-DATA_WIDTH-FRAC_BITS){r_b2[DATA_WIDTH-1]}}, r_b2,
                 {FRAC_BITS{1'b0}}};
        for (int j = 0; j < N_HIDDEN; j++) begin
            w_sum = w_sum + {{(ACC_W-PROD_W){i_prod[j][PROD_W-1]}}, i_prod[j]};
        end
    end

    assign w_rnd = r_sum + ACC_W'(1 << (FRAC_BITS - 1));
    assign w_s   = w_rnd[ACC_W-1:FRAC_BITS];
    assign w_hi  = !w_s[RND_W-1] && (|w_s[RND_W-2:DATA_WIDTH-1]);
    assign w_lo  = w_s[RND_W-1] && !(&w_s[RND_W-2:DATA_WIDTH-1]);

    always_comb begin
        if (w_hi)
            w_clamp = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        else if (w_lo)
            w_clamp = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        else
            w_clamp = w_s[DATA_WIDTH-1:0];
    end

    // offset to unsigned, scale by table size, keep the integer part
    assign w_ofs = {{N_W{1'b0}}, ~w_clamp[DATA_WIDTH-1], w_clamp[DATA_WIDTH-2:0]}
                   * OFS_W'(SIGMOID_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2 <= '0;
        end else if (i_load.en && (i_load.kind == K_OUT_BIAS)) begin
            r_b2 <= i_load.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum) begin
            r_sum  <= w_sum;
            r_hsat <= |i_hsat;
        end
        if (i_ctl.rnd) begin
            r_idx <= w_ofs[DATA_WIDTH +: TBL_W];
            r_sat <= r_hsat || w_hi || w_lo;
        end
        if (i_ctl.lut) begin
            r_prob    <= w_rom[r_idx];
            r_sat_out <= r_sat;
        end
    end

    assign o_probability = r_prob;
    assign o_saturated   = r_sat_out;
endmodule

// ===== src/mlp_9_4_1_inference.sv =====
// Load transaction: accepted when idle, no result.
// Infer transaction: result valid after 9 serial MAC steps in each of 4 parallel
// hidden lanes, then activation, output products, sum, round/clamp and table read
// (held until the previous result is taken); ready again as the result turns valid.
// Reset clears the parameter store to zero and empties the output register.
// ============================================================================
// mlp_9_4_1_inference
// Two-layer perceptron (9 inputs, 4 ReLU hidden units, sigmoid output) in
// signed Q4.12 with four hidden-unit lanes and an output merge stage.
// ============================================================================
module mlp_9_4_1_inference #(
    parameter int SIGMOID_ENTRIES = mlp_pkg::SIGMOID_ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mlp_in_if.sink        i_in,
    mlp_out_if.source     o_out
);
    import mlp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MAC  = 7'b0000010,
        S_ACT  = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_SUM  = 7'b0010000,
        S_RND  = 7'b0100000,
        S_LUT  = 7'b1000000
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    logic [IN_IDX_W-1:0]          r_cnt;
    logic [IN_IDX_W-1:0]          n_cnt;
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic signed [DATA_WIDTH-1:0] r_feat [N_INPUTS];

    logic                         w_acc;
    logic                         w_out_free;
    logic signed [DATA_WIDTH-1:0] w_feat_in [N_INPUTS];
    logic [SLOT_W-1:0]            w_slot;
    logic [SLOT_W-1:0]            w_ofs;
    t_load                        w_load;
    t_lane_ctl                    w_lane_ctl;
    t_merge_ctl                   w_merge_ctl;
    logic signed [PROD_W-1:0]     w_prod [N_HIDDEN];
    logic [N_HIDDEN-1:0]          w_hsat;
    logic [PROB_WIDTH-1:0]        w_prob;
    logic                         w_sat;

    assign w_feat_in[0] = i_in.feature_0;
    assign w_feat_in[1] = i_in.feature_1;
    assign w_feat_in[2] = i_in.feature_2;
    assign w_feat_in[3] = i_in.feature_3;
    assign w_feat_in[4] = i_in.feature_4;
    assign w_feat_in[5] = i_in.feature_5;
    assign w_feat_in[6] = i_in.feature_6;
    assign w_feat_in[7] = i_in.feature_7;
    assign w_feat_in[8] = i_in.feature_8;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;

    // parameter slot decode
    assign w_slot = i_in.param_index;

    always_comb begin
        w_load       = '0;
        w_load.value = i_in.param_value;
        w_load.en    = w_acc && !i_in.action;
        w_ofs        = '0;
        if (w_slot < SLOT_W'(BIAS1_BASE)) begin
            w_load.kind = K_WEIGHT;
            w_load.lane = LANE_W'(w_slot % SLOT_W'(N_HIDDEN));
            w_load.idx  = IN_IDX_W'(w_slot / SLOT_W'(N_HIDDEN));
        end else if (w_slot < SLOT_W'(W2_BASE)) begin
            w_ofs       = w_slot - SLOT_W'(BIAS1_BASE);
            w_load.kind = K_BIAS;
            w_load.lane = w_ofs[LANE_W-1:0];
        end else if (w_slot < SLOT_W'(BIAS2_SLOT)) begin
            w_ofs       = w_slot - SLOT_W'(W2_BASE);
            w_load.kind = K_OUT_WEIGHT;
            w_load.lane = w_ofs[LANE_W-1:0];
        end else if (w_slot == SLOT_W'(BIAS2_SLOT)) begin
            w_load.kind = K_OUT_BIAS;
        end else begin
            w_load.en   = 1'b0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_out.ready;
        case (r_state)
            S_IDLE: begin
                if (w_acc && i_in.action) begin
                    n_state = S_MAC;
                    n_cnt   = '0;
                end
            end
            S_MAC: begin
                if (r_cnt == IN_IDX_W'(N_INPUTS - 1))
                    n_state = S_ACT;
                else
                    n_cnt = r_cnt + 1'b1;
            end
            S_ACT: n_state = S_MUL;
            S_MUL: n_state = S_SUM;
            S_SUM: n_state = S_RND;
            S_RND: n_state = S_LUT;
            S_LUT: begin
                if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.action) begin
            r_feat <= w_feat_in;
        end
    end

    assign w_lane_ctl.start = w_acc && i_in.action;
    assign w_lane_ctl.mac   = (r_state == S_MAC);
    assign w_lane_ctl.act   = (r_state == S_ACT);
    assign w_lane_ctl.mul   = (r_state == S_MUL);
    assign w_lane_ctl.cnt   = r_cnt;

    assign w_merge_ctl.sum  = (r_state == S_SUM);
    assign w_merge_ctl.rnd  = (r_state == S_RND);
    assign w_merge_ctl.lut  = (r_state == S_LUT) && w_out_free;

    for (genvar j = 0; j < N_HIDDEN; j++) begin : g_lane
        mlp_lane #(
            .LANE_ID (j)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_load),
            .i_ctl   (w_lane_ctl),
            .i_feat  (r_feat[r_cnt]),
            .o_prod  (w_prod[j]),
            .o_sat   (w_hsat[j])
        );
    end

    mlp_merge #(
        .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_ctl         (w_merge_ctl),
        .i_prod        (w_prod),
        .i_hsat        (w_hsat),
        .o_probability (w_prob),
        .o_saturated   (w_sat)
    );

    assign o_out.valid       = r_out_valid;
    assign o_out.probability = w_prob;
    assign o_out.saturated   = w_sat;

`ifndef SYNTHESIS
    a_infer_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.action) |=> (r_state == S_MAC) && (r_cnt == '0))
        else $error("infer transaction did not start the MAC sequence");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_in.action) |=> (r_state == S_IDLE))
        else $error("load transaction left the idle state");

    a_mac_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC && r_cnt == IN_IDX_W'(N_INPUTS - 1)) |=> (r_state == S_ACT))
        else $error("MAC sequence did not end after the last feature");

    a_result_from_lut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_LUT))
        else $error("result appeared without a table read");
`endif
endmodule

// ===== dv/mlp_9_4_1_inference_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mlp_9_4_1_inference_test
// Self-checking bench for the 9-4-1 perceptron. Parameter loads and infer
// transactions are sent, mostly in random bursts, while the result side follows
// its own ready pattern, at times never stalling. A local fixed-point model of the
// network and its sigmoid table predicts every probability and saturation flag.
// ============================================================================
module mlp_9_4_1_inference_test;
    import mlp_pkg::*;

    localparam int LUT_DEPTH = SIGMOID_ENTRIES_DEF;
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_INFER = 1'b1;
    localparam logic [SLOT_W-1:0] SLOT_TOP = '1;
    localparam logic signed [DATA_WIDTH-1:0] Q_TOP    = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] Q_BOTTOM = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] Q_ONE    = DATA_WIDTH'(1) << FRAC_BITS;
    localparam longint SUM_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;
    localparam longint unsigned FIX_ONE = 64'd1 << 30;

    typedef logic signed [DATA_WIDTH-1:0] t_feat_vec [N_INPUTS];

    typedef struct packed {
        logic [PROB_WIDTH-1:0] probability;
        logic                  saturated;
    } t_prob_result;

    typedef enum logic [1:0] {
        RX_ALWAYS   = 2'd0,
        RX_RANDOM   = 2'd1,
        RX_PERIODIC = 2'd2,
        RX_SPARSE   = 2'd3
    } t_stall_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic rx_ready = 1'b0;
    t_stall_mode rx_mode = RX_ALWAYS;
    int unsigned stall_phase = 0;

    logic signed [DATA_WIDTH-1:0] param_mirror [N_PARAMS];
    logic [PROB_WIDTH-1:0]        sigmoid_lut  [LUT_DEPTH];
    t_prob_result                 expected_probs [$];
    t_prob_result                 head_result;
    t_feat_vec                    zero_feats;
    int                           mismatch_count = 0;
    int                           burst_left = 0;
    bit                           gaps_on = 1'b0;

    mlp_in_if  in_if ();
    mlp_out_if out_if ();

    assign out_if.ready = rx_ready;

    mlp_9_4_1_inference #(
        .SIGMOID_ENTRIES(LUT_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint unsigned exp_neg_fixed(input longint unsigned span,
                                                      input longint unsigned entries);
        longint unsigned x;
        longint unsigned term;
        longint unsigned e;
        longint          series;
        int              n;
        x      = (span << 30) / (entries * 64'd16);
        term   = FIX_ONE;
        series = longint'(FIX_ONE);
        for (n = 1; n <= 24; n++) begin
            term = ((term * x) >> 30) / longint'(n);
            if (n % 2 == 1)
                series = series - longint'(term);
            else
                series = series + longint'(term);
        end
        e = (series < 0) ? 64'd0 : series;
        repeat (4) e = (e * e) >> 30;
        return e;
    endfunction

    function automatic logic [PROB_WIDTH-1:0] sigmoid_point(input int k);
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned e;
        longint unsigned d;
        longint unsigned v;
        pos = 64'd16 * k + 64'd8;
        neg = 64'd8 * LUT_DEPTH;
        if (pos >= neg) begin
            e = exp_neg_fixed(pos - neg, LUT_DEPTH);
            d = FIX_ONE + e;
            v = (64'd65535 * FIX_ONE + d / 2) / d;
        end else begin
            e = exp_neg_fixed(neg - pos, LUT_DEPTH);
            d = FIX_ONE + e;
            v = (64'd65535 * e + d / 2) / d;
        end
        if (v > 64'd65535)
            v = 64'd65535;
        return v[PROB_WIDTH-1:0];
    endfunction

    // Tracks the parameter store and queues the result of each infer.
    function automatic void predict_mlp(input logic act, input logic [SLOT_W-1:0] slot,
                                        input logic signed [DATA_WIDTH-1:0] value,
                                        input t_feat_vec feats);
        longint       acc;
        longint       sum_q;
        longint       hidden [N_HIDDEN];
        logic         sat;
        longint       lut_idx;
        t_prob_result res;
        if (act == ACT_LOAD) begin
            if (slot < N_PARAMS)
                param_mirror[slot] = value;
            return;
        end
        sat = 1'b0;
        for (int j = 0; j < N_HIDDEN; j++) begin
            acc = longint'(param_mirror[BIAS1_BASE + j]) <<< FRAC_BITS;
            for (int i = 0; i < N_INPUTS; i++)
                acc += longint'(feats[i]) * longint'(param_mirror[i * N_HIDDEN + j]);
            sum_q = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (sum_q < 0)
                sum_q = 0;
            if (sum_q > SUM_MAX) begin
                sum_q = SUM_MAX;
                sat   = 1'b1;
            end
            hidden[j] = sum_q;
        end
        acc = longint'(param_mirror[BIAS2_SLOT]) <<< FRAC_BITS;
        for (int j = 0; j < N_HIDDEN; j++)
            acc += hidden[j] * longint'(param_mirror[W2_BASE + j]);
        sum_q = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (sum_q > SUM_MAX) begin
            sum_q = SUM_MAX;
            sat   = 1'b1;
        end
        if (sum_q < SUM_MIN) begin
            sum_q = SUM_MIN;
            sat   = 1'b1;
        end
        lut_idx = ((sum_q - SUM_MIN) * LUT_DEPTH) >>> DATA_WIDTH;
        if (lut_idx > LUT_DEPTH - 1)
            lut_idx = LUT_DEPTH - 1;
        res.probability = sigmoid_lut[int'(lut_idx)];
        res.saturated   = sat;
        expected_probs.push_back(res);
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] rand_q(input int lo, input int hi);
        logic signed [DATA_WIDTH-1:0] raw;
        raw = DATA_WIDTH'($urandom);
        return raw >>> $urandom_range(lo, hi);
    endfunction

    task automatic send_txn(input logic act, input logic [SLOT_W-1:0] slot,
                            input logic signed [DATA_WIDTH-1:0] value,
                            input t_feat_vec feats);
        in_if.valid       <= 1'b1;
        in_if.action      <= act;
        in_if.param_index <= slot;
        in_if.param_value <= value;
        in_if.feature_0   <= feats[0];
        in_if.feature_1   <= feats[1];
        in_if.feature_2   <= feats[2];
        in_if.feature_3   <= feats[3];
        in_if.feature_4   <= feats[4];
        in_if.feature_5   <= feats[5];
        in_if.feature_6   <= feats[6];
        in_if.feature_7   <= feats[7];
        in_if.feature_8   <= feats[8];
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        predict_mlp(act, slot, value, feats);
        if (gaps_on && burst_left <= 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    task automatic load_param(input logic [SLOT_W-1:0] slot,
                              input logic signed [DATA_WIDTH-1:0] value);
        send_txn(ACT_LOAD, slot, value, zero_feats);
    endtask

    task automatic run_infer(input t_feat_vec feats);
        send_txn(ACT_INFER, SLOT_W'($urandom), DATA_WIDTH'($urandom), feats);
    endtask

    task automatic test_cleared_store();
        t_feat_vec fv;
        foreach (fv[i]) fv[i] = '0;
        run_infer(fv);
        foreach (fv[i]) fv[i] = Q_TOP;
        run_infer(fv);
        foreach (fv[i]) fv[i] = Q_BOTTOM;
        run_infer(fv);
    endtask

    task automatic test_ignored_slots();
        load_param(SLOT_W'(N_PARAMS), Q_TOP);
        load_param(SLOT_TOP, Q_BOTTOM);
        run_infer(zero_feats);
    endtask

    task automatic test_output_extremes();
        load_param(SLOT_W'(BIAS2_SLOT), Q_BOTTOM);
        run_infer(zero_feats);
        load_param(SLOT_W'(BIAS2_SLOT), Q_TOP);
        run_infer(zero_feats);
        load_param(SLOT_W'(BIAS2_SLOT), '0);
    endtask

    task automatic test_relu_and_clamp();
        t_feat_vec fv;
        fv = zero_feats;
        load_param(SLOT_W'(BIAS1_BASE), Q_BOTTOM);
        load_param(SLOT_W'(W2_BASE), Q_TOP);
        load_param(SLOT_W'(0), Q_ONE);
        run_infer(fv);
        fv[0] = Q_TOP;
        load_param(SLOT_W'(BIAS1_BASE), Q_TOP);
        load_param(SLOT_W'(0), Q_TOP);
        run_infer(fv);
        load_param(SLOT_W'(W2_BASE), Q_BOTTOM);
        run_infer(fv);
    endtask

    task automatic test_random_traffic();
        t_feat_vec fv;
        int        counted;
        int        pick;
        int        set_lo;
        int        set_hi;
        int        feat_lo;
        counted = 0;
        set_lo  = 3;
        set_hi  = 8;
        while (counted < 1560) begin
            if (counted == 0 || $urandom_range(0, 99) < 2) begin
                set_lo  = $urandom_range(0, 5);
                set_hi  = set_lo + $urandom_range(1, 8);
                rx_mode <= t_stall_mode'($urandom_range(0, 3));
                gaps_on = ($urandom_range(0, 2) != 0);
                for (int s = 0; s < N_PARAMS; s++) begin
                    load_param(SLOT_W'(s), rand_q(set_lo, set_hi));
                    counted++;
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                feat_lo = $urandom_range(0, 4);
                foreach (fv[i]) fv[i] = rand_q(feat_lo, feat_lo + 7);
                run_infer(fv);
                counted++;
            end else if (pick < 92) begin
                load_param(SLOT_W'($urandom_range(0, N_PARAMS - 1)), rand_q(set_lo, set_hi));
                counted++;
            end else begin
                load_param(SLOT_W'($urandom_range(N_PARAMS, 2 ** SLOT_W - 1)), rand_q(0, 0));
            end
        end
    endtask

    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        case (rx_mode)
            RX_ALWAYS:   rx_ready <= 1'b1;
            RX_RANDOM:   rx_ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: rx_ready <= ((stall_phase % 7) < 3);
            default:     rx_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_probs.size() == 0) begin
                $display("%0t: unexpected transaction, probability %0d saturated %0b",
                         $time, out_if.probability, out_if.saturated);
                mismatch_count++;
            end else begin
                head_result = expected_probs.pop_front();
                if (out_if.probability !== head_result.probability) begin
                    $display("%0t: probability mismatch, expected %0d actual %0d",
                             $time, head_result.probability, out_if.probability);
                    mismatch_count++;
                end
                if (out_if.saturated !== head_result.saturated) begin
                    $display("%0t: saturated mismatch, expected %0b actual %0b",
                             $time, head_result.saturated, out_if.saturated);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        for (int k = 0; k < LUT_DEPTH; k++)
            sigmoid_lut[k] = sigmoid_point(k);
        foreach (param_mirror[i]) param_mirror[i] = '0;
        foreach (zero_feats[i]) zero_feats[i] = '0;
        in_if.valid       <= 1'b0;
        in_if.action      <= ACT_LOAD;
        in_if.param_index <= '0;
        in_if.param_value <= '0;
        in_if.feature_0   <= '0;
        in_if.feature_1   <= '0;
        in_if.feature_2   <= '0;
        in_if.feature_3   <= '0;
        in_if.feature_4   <= '0;
        in_if.feature_5   <= '0;
        in_if.feature_6   <= '0;
        in_if.feature_7   <= '0;
        in_if.feature_8   <= '0;
        i_rst_n           <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rx_mode <= RX_RANDOM;
        gaps_on = 1'b1;
        @(posedge i_clk);

        test_cleared_store();
        test_ignored_slots();
        test_output_extremes();
        test_relu_and_clamp();
        test_random_traffic();

        in_if.valid <= 1'b0;
        while (expected_probs.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
